// File: hdl/tsc_pkg.sv
`default_nettype none

package tsc_pkg;

  // Input and output payload widths.
  localparam int ANGLE_W = 32;
  localparam int VALUE_W = 32;

  // Range reduction works in Q.52. The signed angle needs 61 bits, and the
  // folded non-negative angle stays below 2^60.
  localparam int FRAC_SHIFT = 28;
  localparam int T_W        = 61;
  localparam int M_W        = 60;
  localparam int RED_STEPS  = 6;

  // Reduced angle in Q.30 and the values derived from it.
  localparam int X_SHIFT     = 22;
  localparam int X_W         = 33;
  localparam int UX_W        = 32;
  localparam int X2_SHIFT    = 30;
  localparam int X2_W        = 34;
  localparam int Q_W         = 31;
  localparam int RECIP_W     = 32;
  localparam int RECIP_SHIFT = 34;
  localparam int TERM_W      = 34;
  localparam int TERM_SHIFT  = 30;
  localparam int SUM_W       = 36;

  localparam logic signed [T_W-1:0] PI_Q52      = 61'sh3243F6A8885A31;
  localparam logic signed [T_W-1:0] HALF_PI_Q52 = 61'sh1921FB54442D18;
  localparam logic signed [T_W-1:0] TWO_PI_Q52  = 61'sh6487ED5110B461;
  localparam logic signed [T_W-1:0] PI_HALF_PI_Q52 = PI_Q52 + HALF_PI_Q52;
  localparam logic signed [T_W-1:0] FOLD_Q52    = TWO_PI_Q52 <<< (RED_STEPS - 1);

  localparam logic signed [SUM_W-1:0] ONE_Q30     = 36'sd1073741824;
  localparam logic signed [SUM_W-1:0] NEG_ONE_Q30 = -36'sd1073741824;

  typedef logic signed [X_W-1:0]     angle_q30_t;
  typedef logic signed [VALUE_W-1:0] value_q30_t;

endpackage

`default_nettype wire

// File: hdl/tsc_reduce.sv
`default_nettype none

// Brings the angle (plus pi/2 for cosine) into [-pi, pi) in Q.52 and
// truncates it to Q.30. Nine register stages, all advancing on en.
module tsc_reduce (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 en,
  input  wire                                 in_valid,
  input  wire                                 cmd,
  input  wire  signed [tsc_pkg::ANGLE_W-1:0]  angle,
  output logic                                out_valid,
  output tsc_pkg::angle_q30_t                 x
);

  // One restoring step: take off 2*pi*2^k when it fits.
  function automatic logic [tsc_pkg::M_W-1:0] red_step(
    input logic [tsc_pkg::M_W-1:0] m,
    input int unsigned             k
  );
    logic [tsc_pkg::M_W-1:0] step;
    step = tsc_pkg::M_W'(tsc_pkg::TWO_PI_Q52) << k;
    return (m >= step) ? (m - step) : m;
  endfunction

  logic                           s0_valid;
  logic signed [tsc_pkg::T_W-1:0] s0_t;
  logic                           s1_valid;
  logic [tsc_pkg::M_W-1:0]        s1_m;
  logic                           rd_valid [0:tsc_pkg::RED_STEPS-1];
  logic [tsc_pkg::M_W-1:0]        rd_m     [0:tsc_pkg::RED_STEPS-1];
  logic signed [tsc_pkg::T_W-1:0] a_ext;
  logic signed [tsc_pkg::T_W-1:0] xr;

  assign a_ext = tsc_pkg::T_W'(signed'({angle, {tsc_pkg::FRAC_SHIFT{1'b0}}}));
  assign xr    = signed'({1'b0, rd_m[tsc_pkg::RED_STEPS-1]}) - tsc_pkg::PI_Q52;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid  <= 1'b0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      for (int j = 0; j < tsc_pkg::RED_STEPS; j++) begin
        rd_valid[j] <= 1'b0;
      end
    end else if (en) begin
      s0_valid    <= in_valid;
      s1_valid    <= s0_valid;
      rd_valid[0] <= s1_valid;
      for (int j = 1; j < tsc_pkg::RED_STEPS; j++) begin
        rd_valid[j] <= rd_valid[j-1];
      end
      out_valid <= rd_valid[tsc_pkg::RED_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Shift pi up front so that the final subtraction lands in [-pi, pi).
      s0_t <= a_ext + (cmd ? tsc_pkg::PI_HALF_PI_Q52 : tsc_pkg::PI_Q52);
      // A negative angle is lifted by 64*pi, which covers the whole input range.
      s1_m <= s0_t[tsc_pkg::T_W-1] ? tsc_pkg::M_W'(s0_t + tsc_pkg::FOLD_Q52)
                                   : tsc_pkg::M_W'(s0_t);
      rd_m[0] <= red_step(s1_m, tsc_pkg::RED_STEPS - 1);
      for (int j = 1; j < tsc_pkg::RED_STEPS; j++) begin
        rd_m[j] <= red_step(rd_m[j-1], tsc_pkg::RED_STEPS - 1 - j);
      end
      x <= xr[tsc_pkg::X_SHIFT +: tsc_pkg::X_W];
    end
  end

endmodule

`default_nettype wire

// File: hdl/tsc_series.sv
`default_nettype none

// Evaluates the truncated sine series on a reduced angle and saturates the
// sum. Each term has its own divider by a constant and three stages of
// multiply, combine and accumulate.
module tsc_series #(
  parameter int SERIES_TERMS = 7
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   en,
  input  wire                   in_valid,
  input  tsc_pkg::angle_q30_t   x,
  output logic                  out_valid,
  output tsc_pkg::value_q30_t   value
);

  localparam int D_MAX  = 2 * SERIES_TERMS * (2 * SERIES_TERMS + 1);
  localparam int REM_W  = $clog2(2 * D_MAX);
  localparam int SPLIT  = 17;
  localparam int LO_W   = SPLIT + tsc_pkg::Q_W;
  localparam int HI_W   = tsc_pkg::TERM_W - SPLIT + tsc_pkg::Q_W + 1;
  localparam int PROD_W = HI_W + SPLIT;
  localparam int Y_W    = PROD_W - tsc_pkg::TERM_SHIFT;

  logic                              ab_valid;
  tsc_pkg::angle_q30_t               ab_x;
  logic [tsc_pkg::UX_W-1:0]          ab_ux;
  logic                              sq_valid;
  tsc_pkg::angle_q30_t               sq_x;
  logic [tsc_pkg::X2_W-1:0]          sq_x2;
  logic [2*tsc_pkg::UX_W-1:0]        sq_prod;
  logic                              d1_valid;
  tsc_pkg::angle_q30_t               d1_x;
  logic [REM_W-1:0]                  d1_x2lo;
  logic                              d2_valid;
  tsc_pkg::angle_q30_t               d2_x;
  logic [REM_W-1:0]                  d2_x2lo;
  logic                              d3_valid;
  tsc_pkg::angle_q30_t               d3_x;

  logic                              bd_valid [1:SERIES_TERMS];
  logic signed [tsc_pkg::TERM_W-1:0] bd_term  [1:SERIES_TERMS];
  logic signed [tsc_pkg::SUM_W-1:0]  bd_sum   [1:SERIES_TERMS];
  logic signed [tsc_pkg::SUM_W-1:0]  last_sum;

  assign sq_prod  = ab_ux * ab_ux;
  assign last_sum = bd_sum[SERIES_TERMS];

  always_ff @(posedge clk) begin
    if (rst) begin
      ab_valid  <= 1'b0;
      sq_valid  <= 1'b0;
      d1_valid  <= 1'b0;
      d2_valid  <= 1'b0;
      d3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      ab_valid  <= in_valid;
      sq_valid  <= ab_valid;
      d1_valid  <= sq_valid;
      d2_valid  <= d1_valid;
      d3_valid  <= d2_valid;
      out_valid <= bd_valid[SERIES_TERMS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ab_x    <= x;
      ab_ux   <= tsc_pkg::UX_W'(x[tsc_pkg::X_W-1] ? -x : x);
      sq_x    <= ab_x;
      sq_x2   <= sq_prod[tsc_pkg::X2_SHIFT +: tsc_pkg::X2_W];
      d1_x    <= sq_x;
      d1_x2lo <= sq_x2[REM_W-1:0];
      d2_x    <= d1_x;
      d2_x2lo <= d1_x2lo;
      d3_x    <= d2_x;
      if (last_sum > tsc_pkg::ONE_Q30) begin
        value <= tsc_pkg::VALUE_W'(tsc_pkg::ONE_Q30);
      end else if (last_sum < tsc_pkg::NEG_ONE_Q30) begin
        value <= tsc_pkg::VALUE_W'(tsc_pkg::NEG_ONE_Q30);
      end else begin
        value <= tsc_pkg::VALUE_W'(last_sum);
      end
    end
  end

  for (genvar gi = 1; gi <= SERIES_TERMS; gi++) begin : g_term
    localparam int DIV = 2 * gi * (2 * gi + 1);
    localparam int DLY = 3 * (gi - 1);
    localparam logic [tsc_pkg::RECIP_W-1:0] RECIP =
      tsc_pkg::RECIP_W'((64'd1 << tsc_pkg::RECIP_SHIFT) / DIV);
    localparam logic [REM_W-1:0] DIV_C = REM_W'(DIV);

    logic [tsc_pkg::X2_W+tsc_pkg::RECIP_W-1:0] d1_prod;
    logic [tsc_pkg::Q_W-1:0]                   d1_q0;
    logic [tsc_pkg::Q_W+REM_W-1:0]             d2_prod;
    logic [tsc_pkg::Q_W-1:0]                   d2_q0;
    logic [REM_W-1:0]                          d2_lo;
    logic [REM_W-1:0]                          rem;
    logic [tsc_pkg::Q_W-1:0]                   d3_q;
    logic [tsc_pkg::Q_W-1:0]                   q_use;
    logic                                      t_valid;
    logic signed [tsc_pkg::TERM_W-1:0]         t_in;
    logic signed [tsc_pkg::SUM_W-1:0]          s_in;
    logic [LO_W-1:0]                           lo_prod;
    logic signed [HI_W-1:0]                    hi_prod;
    logic                                      mul_valid;
    logic [LO_W-1:0]                           mul_lo;
    logic signed [HI_W-1:0]                    mul_hi;
    logic signed [tsc_pkg::SUM_W-1:0]          mul_sum;
    logic                                      add_valid;
    logic signed [PROD_W-1:0]                  add_p;
    logic signed [tsc_pkg::SUM_W-1:0]          add_sum;
    logic signed [Y_W-1:0]                     acc_y;

    // The reciprocal estimate is at most one short; the remainder fixes it.
    assign d1_prod = sq_x2 * RECIP;
    assign d2_prod = d1_q0 * DIV_C;
    assign rem     = d2_x2lo - d2_lo;

    always_ff @(posedge clk) begin
      if (en) begin
        d1_q0 <= d1_prod[tsc_pkg::RECIP_SHIFT +: tsc_pkg::Q_W];
        d2_q0 <= d1_q0;
        d2_lo <= d2_prod[REM_W-1:0];
        d3_q  <= (rem >= DIV_C) ? d2_q0 + 1'b1 : d2_q0;
      end
    end

    // The quotient waits for the term that it scales.
    if (DLY == 0) begin : g_nodly
      assign q_use = d3_q;
    end else begin : g_dly
      logic [tsc_pkg::Q_W-1:0] qd [1:DLY];
      always_ff @(posedge clk) begin
        if (en) begin
          qd[1] <= d3_q;
          for (int k = 2; k <= DLY; k++) begin
            qd[k] <= qd[k-1];
          end
        end
      end
      assign q_use = qd[DLY];
    end

    if (gi == 1) begin : g_first
      assign t_valid = d3_valid;
      assign t_in    = tsc_pkg::TERM_W'(d3_x);
      assign s_in    = tsc_pkg::SUM_W'(d3_x);
    end else begin : g_next
      assign t_valid = bd_valid[gi-1];
      assign t_in    = bd_term[gi-1];
      assign s_in    = bd_sum[gi-1];
    end

    // The term times the quotient, split into two narrower products.
    assign lo_prod = {1'b0, t_in[SPLIT-1:0]} * q_use;
    assign hi_prod = signed'(t_in[tsc_pkg::TERM_W-1:SPLIT]) * signed'({1'b0, q_use});
    assign acc_y   = add_p[PROD_W-1:tsc_pkg::TERM_SHIFT];

    always_ff @(posedge clk) begin
      if (rst) begin
        mul_valid    <= 1'b0;
        add_valid    <= 1'b0;
        bd_valid[gi] <= 1'b0;
      end else if (en) begin
        mul_valid    <= t_valid;
        add_valid    <= mul_valid;
        bd_valid[gi] <= add_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        mul_lo      <= lo_prod;
        mul_hi      <= hi_prod;
        mul_sum     <= s_in;
        add_p       <= (PROD_W'(mul_hi) <<< SPLIT) + PROD_W'(signed'({1'b0, mul_lo}));
        add_sum     <= mul_sum;
        bd_term[gi] <= tsc_pkg::TERM_W'(-acc_y);
        bd_sum[gi]  <= add_sum - tsc_pkg::SUM_W'(acc_y);
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/taylor_sine_cosine_unit.sv
`default_nettype none

// Channel   Handshake              Payload
// request   req_valid, req_ready   cmd (0 sine, 1 cosine), angle (Q8.24, radians)
// response  rsp_valid, rsp_ready   value (Q2.30, within plus or minus one)
//
// One transaction is taken in every cycle while the response side keeps up.
// A result passes through nine reduction stages, absolute value and square, a
// three-stage divider per term, three stages per term, saturation and the output
// register. Reset clears every valid bit and leaves the datapath as it is. A
// stalled response parks one result in a skid register, and the pipeline freezes
// only while it is full.
module taylor_sine_cosine_unit #(
  parameter int SERIES_TERMS = 7
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                req_valid,
  output logic                               req_ready,
  input  wire                                cmd,
  input  wire  signed [tsc_pkg::ANGLE_W-1:0] angle,
  output logic                               rsp_valid,
  input  wire                                rsp_ready,
  output logic signed [tsc_pkg::VALUE_W-1:0] value
);

  logic                en;
  logic                red_valid;
  tsc_pkg::angle_q30_t red_x;
  logic                pipe_valid;
  tsc_pkg::value_q30_t pipe_value;
  logic                skid_valid;
  tsc_pkg::value_q30_t skid_value;

  // The whole datapath moves together. It stops only when the skid register
  // holds a result, which is a registered condition and so keeps the enable
  // off any long combinational path from the response side.
  assign en        = !skid_valid;
  assign req_ready = en;

  tsc_reduce u_reduce (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (req_valid),
    .cmd       (cmd),
    .angle     (angle),
    .out_valid (red_valid),
    .x         (red_x)
  );

  tsc_series #(
    .SERIES_TERMS (SERIES_TERMS)
  ) u_series (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (red_valid),
    .x         (red_x),
    .out_valid (pipe_valid),
    .value     (pipe_value)
  );

  // Output register with a single skid entry behind it. A result leaving
  // the pipeline goes straight to the output when the output is free or
  // being taken; otherwise it is parked, and the pipeline halts next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (rsp_ready) begin
        rsp_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (pipe_valid) begin
      if (!rsp_valid || rsp_ready) begin
        rsp_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (rsp_ready) begin
        value <= skid_value;
      end
    end else if (pipe_valid) begin
      if (!rsp_valid || rsp_ready) begin
        value <= pipe_value;
      end else begin
        skid_value <= pipe_value;
      end
    end
  end

endmodule

`default_nettype wire
